@@ rtl/gdl90_frame_encoder_core_macros.svh @@
// Assertion helpers for the frame encoder checker.
`ifndef GDL90_FRAME_ENCODER_CORE_MACROS_SVH
`define GDL90_FRAME_ENCODER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define GFE_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GFE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gfe_pkg.sv @@
package gfe_pkg;

  localparam logic [7:0]  FRAME_FLAG  = 8'h7E;
  localparam logic [7:0]  FRAME_ESC   = 8'h7D;
  localparam logic [7:0]  ESC_XOR     = 8'h20;
  localparam logic [15:0] FCS_POLY    = 16'h1021;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;
  localparam logic [4:0]  MAX_PAYLOAD = 5'd27;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } gfe_in_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       run_last;
    logic       frame_done;
    logic       overlength;
  } gfe_out_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic        open_frame;
    logic [7:0]  data_byte;
    logic        close_frame;
    logic [15:0] fcs;
    logic        overlength;
  } gfe_job_t;

  function automatic logic [15:0] fcs_entry(input logic [7:0] hi);
    logic [15:0] v;
    v = {hi, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ FCS_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic is_special(input logic [7:0] b);
    return (b == FRAME_FLAG) || (b == FRAME_ESC);
  endfunction

endpackage

@@ rtl/gfe_fifo.sv @@
module gfe_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gfe_pkg::gfe_job_t push_data,
  output logic             full,
  input  logic             pop,
  output gfe_pkg::gfe_job_t pop_data,
  output logic             not_empty
);
  import gfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  gfe_job_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (AW + 1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/gfe_front.sv @@
module gfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gfe_pkg::gfe_in_t  in_item,
  output logic              push,
  output gfe_pkg::gfe_job_t push_data,
  input  logic              full
);
  import gfe_pkg::*;

  logic        inside_r, inside_nxt;
  logic [15:0] fcs_r, fcs_nxt;
  logic [4:0]  count_r, count_nxt;

  logic [15:0] fcs_base;
  logic [4:0]  count_cur;
  logic [15:0] fcs_new;
  logic        accept;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept;

  always_comb begin
    fcs_base  = inside_r ? fcs_r : '0;
    count_cur = '0;
    if (inside_r) begin
      count_cur = (count_r < COUNT_MAX) ? count_r + 1'b1 : count_r;
    end
    fcs_new = fcs_entry(fcs_base[15:8]) ^ {fcs_base[7:0], 8'h00}
              ^ {8'h00, in_item.data_byte};

    push_data.open_frame  = !inside_r;
    push_data.data_byte   = in_item.data_byte;
    push_data.close_frame = in_item.end_of_message;
    push_data.fcs         = fcs_new;
    push_data.overlength  = (count_cur > MAX_PAYLOAD);

    inside_nxt = inside_r;
    fcs_nxt    = fcs_r;
    count_nxt  = count_r;
    if (accept) begin
      if (in_item.end_of_message) begin
        inside_nxt = 1'b0;
        fcs_nxt    = '0;
        count_nxt  = '0;
      end else begin
        inside_nxt = 1'b1;
        fcs_nxt    = fcs_new;
        count_nxt  = count_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      fcs_r    <= '0;
      count_r  <= '0;
    end else begin
      inside_r <= inside_nxt;
      fcs_r    <= fcs_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/gfe_back.sv @@
module gfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  gfe_pkg::gfe_job_t job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output gfe_pkg::gfe_out_t out_item
);
  import gfe_pkg::*;

  typedef enum logic [4:0] {
    ST_HEAD  = 5'b00001,
    ST_DATA  = 5'b00010,
    ST_FLO   = 5'b00100,
    ST_FHI   = 5'b01000,
    ST_CLOSE = 5'b10000
  } gfe_seg_t;

  gfe_seg_t st_r, st_nxt, seg, seg_next;
  logic     esc_r, esc_nxt;
  logic     out_valid_r, out_valid_nxt;
  gfe_out_t out_item_r;

  logic [7:0] raw;
  logic       stuffable;
  logic       seg_done;
  logic       job_end;
  logic       load;
  gfe_out_t   cur;

  assign load = job_valid && (!out_valid_r || out_ready);

  always_comb begin
    seg = st_r;
    if (st_r == ST_HEAD && !job.open_frame) begin
      seg = ST_DATA;
    end

    raw       = job.data_byte;
    stuffable = 1'b0;
    seg_next  = ST_HEAD;
    case (seg)
      ST_HEAD: begin
        raw      = FRAME_FLAG;
        seg_next = ST_DATA;
      end
      ST_DATA: begin
        raw       = job.data_byte;
        stuffable = 1'b1;
        seg_next  = job.close_frame ? ST_FLO : ST_HEAD;
      end
      ST_FLO: begin
        raw       = job.fcs[7:0];
        stuffable = 1'b1;
        seg_next  = ST_FHI;
      end
      ST_FHI: begin
        raw       = job.fcs[15:8];
        stuffable = 1'b1;
        seg_next  = ST_CLOSE;
      end
      ST_CLOSE: begin
        raw      = FRAME_FLAG;
        seg_next = ST_HEAD;
      end
      default: begin
        raw      = FRAME_FLAG;
        seg_next = ST_HEAD;
      end
    endcase

    seg_done = !stuffable || esc_r || !is_special(raw);
    job_end  = seg_done && (seg == ST_CLOSE || (seg == ST_DATA && !job.close_frame));

    cur.wire_byte  = raw;
    if (stuffable && esc_r) begin
      cur.wire_byte = raw ^ ESC_XOR;
    end else if (stuffable && is_special(raw)) begin
      cur.wire_byte = FRAME_ESC;
    end
    cur.run_last   = job_end;
    cur.frame_done = (seg == ST_CLOSE);
    cur.overlength = (seg == ST_CLOSE) && job.overlength;

    pop     = load && job_end;
    st_nxt  = st_r;
    esc_nxt = esc_r;
    if (load) begin
      if (job_end) begin
        st_nxt  = ST_HEAD;
        esc_nxt = 1'b0;
      end else if (seg_done) begin
        st_nxt  = seg_next;
        esc_nxt = 1'b0;
      end else begin
        st_nxt  = seg;
        esc_nxt = 1'b1;
      end
    end

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_HEAD;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/gdl90_frame_encoder_core.sv @@
// GDL90 frame encoder. Message bytes come in one request per cycle while the queue
// is not full (ID byte first, end_of_message on the last); the block wraps them in
// 0x7E flags, escapes 0x7E/0x7D, and appends the CRC-16 (poly 0x1021) FCS low byte
// first. The front classifies each request and updates the FCS combinationally,
// pushing it into a QUEUE_DEPTH queue; the back serializer emits one wire byte per
// cycle through an output register unless out_ready stalls it. A request emits its
// data byte, escaped if special, after an opening flag if it opens a frame and before
// the FCS and closing flag if it ends one; the queue takes requests while earlier
// ones drain. overlength marks the closing flag of a payload exceeding 28 bytes.
module gdl90_frame_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gfe_pkg::gfe_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output gfe_pkg::gfe_out_t out_item
);
  import gfe_pkg::*;

  logic     push, full, pop, job_valid;
  gfe_job_t push_data, job;

  gfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  gfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (job),
    .not_empty (job_valid)
  );

  gfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ rtl/gfe_checker.sv @@
`include "gdl90_frame_encoder_core_macros.svh"

module gfe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input gfe_pkg::gfe_out_t out_item
);
  import gfe_pkg::*;

  `GFE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed while stalled")
  `GFE_ASSERT(a_close_flag, clk, rst_n, out_valid && out_item.frame_done |-> out_item.wire_byte == FRAME_FLAG && out_item.run_last, "closing byte is not a final flag")
  `GFE_ASSERT(a_over_on_close, clk, rst_n, out_valid && out_item.overlength |-> out_item.frame_done, "overlength outside closing flag")
  `GFE_ASSERT(a_run_continues, clk, rst_n, out_valid && out_ready && !out_item.run_last |=> out_valid, "gap inside a request's byte run")
  `GFE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind gdl90_frame_encoder_core gfe_checker u_gfe_checker (.*);
